### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define SMINV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// cond at one edge implies res at the next edge
`define SMINV_ASSERT_NEXT(lbl, clk, rstn, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) else $error(msg);

`endif

### design/sminv_pkg.sv
// Package: shared types and constants of the small matrix inverse
`timescale 1ns / 1ps
package sminv_pkg;

  localparam int unsigned OUT_WIDTH = 48;
  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned NUM_PRODS = 18;

  localparam logic [2:0] ORDER_TWO = 3'd2;
  localparam logic [2:0] ORDER_THREE = 3'd3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SINGULAR  = 2'd1,
    STATUS_BAD_ORDER = 2'd2
  } status_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } lane_ctrl_t;

  // adjugate entry m = a[LHS[2m]] * a[RHS[2m]] - a[LHS[2m+1]] * a[RHS[2m+1]]
  localparam int unsigned PROD_LHS [NUM_PRODS] =
    '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned PROD_RHS [NUM_PRODS] =
    '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

### design/sminv_if.sv
// Interfaces: input and result channels of the small matrix inverse
`timescale 1ns / 1ps
interface sminv_in_if #(
  parameter int EntryWidth = 12
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   order;
  logic signed [EntryWidth-1:0] a_00;
  logic signed [EntryWidth-1:0] a_01;
  logic signed [EntryWidth-1:0] a_02;
  logic signed [EntryWidth-1:0] a_10;
  logic signed [EntryWidth-1:0] a_11;
  logic signed [EntryWidth-1:0] a_12;
  logic signed [EntryWidth-1:0] a_20;
  logic signed [EntryWidth-1:0] a_21;
  logic signed [EntryWidth-1:0] a_22;

  modport source (output valid, order, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                  input ready);
  modport sink (input valid, order, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                output ready);
endinterface

interface sminv_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] inv_00;
  logic signed [47:0] inv_01;
  logic signed [47:0] inv_02;
  logic signed [47:0] inv_10;
  logic signed [47:0] inv_11;
  logic signed [47:0] inv_12;
  logic signed [47:0] inv_20;
  logic signed [47:0] inv_21;
  logic signed [47:0] inv_22;
  logic [1:0]         status;

  modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                  inv_21, inv_22, status, input ready);
  modport sink (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                inv_21, inv_22, status, output ready);
endinterface

### design/sminv_front.sv
// Front end: products, adjugate, determinant and lane operands
`timescale 1ns / 1ps
module sminv_front #(
  parameter int EW = 12,
  parameter int FB = 24
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2:0]                 order_i,
  input  logic signed [EW-1:0]       a_i [9],
  output logic [2*EW+FB-1:0]         num_o [9],
  output logic [3*EW+2:0]            den_o,
  output sminv_pkg::lane_ctrl_t      ctrl_o [9],
  output sminv_pkg::status_e         status_o
);
  import sminv_pkg::*;

  localparam int PW  = 2 * EW;
  localparam int AW  = 2 * EW + 1;
  localparam int DPW = EW + AW;
  localparam int DTW = DPW + 2;

  // stage 1: products
  logic signed [EW-1:0]  a1_q [9];
  logic [2:0]            order1_q;
  logic signed [PW-1:0]  p1_q [NUM_PRODS];
  // stage 2: adjugate
  logic signed [EW-1:0]  a2_q [9];
  logic [2:0]            order2_q;
  logic signed [AW-1:0]  adj2_d [9];
  logic signed [AW-1:0]  adj2_q [9];
  // stage 3: determinant terms
  logic [2:0]            order3_q;
  logic signed [AW-1:0]  adj3_q [9];
  logic signed [DPW-1:0] dp3_q [3];
  // stage 4: determinant
  logic [2:0]            order4_q;
  logic signed [AW-1:0]  adj4_q [9];
  logic signed [DTW-1:0] det4_q;
  // stage 5: operands
  status_e               status5_d;
  logic                  det_neg;
  logic [DTW-1:0]        det_mag;
  logic [AW-1:0]         adj_mag [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q     <= a_i;
      order1_q <= order_i;
      for (int k = 0; k < NUM_PRODS; k++) begin
        p1_q[k] <= a_i[PROD_LHS[k]] * a_i[PROD_RHS[k]];
      end
    end
  end

  always_comb begin
    for (int m = 0; m < 9; m++) begin
      adj2_d[m] = '0;
    end
    case (order1_q)
      ORDER_THREE: begin
        for (int m = 0; m < 9; m++) begin
          adj2_d[m] = AW'(p1_q[2*m]) - AW'(p1_q[2*m+1]);
        end
      end
      ORDER_TWO: begin
        adj2_d[0] = AW'(a1_q[4]);
        adj2_d[1] = -AW'(a1_q[1]);
        adj2_d[3] = -AW'(a1_q[3]);
        adj2_d[4] = AW'(a1_q[0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q     <= a1_q;
      order2_q <= order1_q;
      adj2_q   <= adj2_d;
      order3_q <= order2_q;
      adj3_q   <= adj2_q;
      for (int j = 0; j < 3; j++) begin
        dp3_q[j] <= a2_q[j] * adj2_q[3*j];
      end
      order4_q <= order3_q;
      adj4_q   <= adj3_q;
      det4_q   <= DTW'(dp3_q[0]) + DTW'(dp3_q[1]) + DTW'(dp3_q[2]);
    end
  end

  always_comb begin
    det_neg = det4_q[DTW-1];
    det_mag = det_neg ? -det4_q : det4_q;
    for (int m = 0; m < 9; m++) begin
      adj_mag[m] = adj4_q[m][AW-1] ? -adj4_q[m] : adj4_q[m];
    end
    if (!(order4_q inside {ORDER_TWO, ORDER_THREE})) begin
      status5_d = STATUS_BAD_ORDER;
    end else if (det4_q == '0) begin
      status5_d = STATUS_SINGULAR;
    end else begin
      status5_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o    <= det_mag;
      status_o <= status5_d;
      for (int m = 0; m < 9; m++) begin
        num_o[m]       <= {adj_mag[m][PW-1:0], {FB{1'b0}}};
        ctrl_o[m].neg  <= adj4_q[m][AW-1] ^ det_neg;
        ctrl_o[m].zero <= (adj4_q[m] == '0) || (status5_d != STATUS_OK);
      end
    end
  end

endmodule

### design/sminv_lane.sv
// Divider lane: pipelined restoring divide, rounding and saturation
`timescale 1ns / 1ps
module sminv_lane #(
  parameter int NW = 48,
  parameter int DW = 39
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [NW-1:0]                        num_i,
  input  logic [DW-1:0]                        den_i,
  input  sminv_pkg::lane_ctrl_t                ctrl_i,
  output logic signed [sminv_pkg::OUT_WIDTH-1:0] inv_o
);
  import sminv_pkg::*;

  localparam int QW = (NW + 1 > OUT_WIDTH) ? NW + 1 : OUT_WIDTH;

  logic [DW-1:0] rem_s [NW+1];
  logic [NW-1:0] quo_s [NW+1];
  logic [NW-1:0] num_s [NW+1];
  logic [DW-1:0] den_s [NW+1];
  lane_ctrl_t    ctrl_s [NW+1];

  assign rem_s[0]  = '0;
  assign quo_s[0]  = '0;
  assign num_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign ctrl_s[0] = ctrl_i;

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_s[k], num_s[k][NW-1-k]};
    assign ge    = trial >= {1'b0, den_s[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
        quo_s[k+1]  <= {quo_s[k][NW-2:0], ge};
        num_s[k+1]  <= num_s[k];
        den_s[k+1]  <= den_s[k];
        ctrl_s[k+1] <= ctrl_s[k];
      end
    end
  end

  logic          rnd;
  logic [QW-1:0] q_rnd, lim, q_sat, q_sgn;

  always_comb begin
    rnd   = {rem_s[NW], 1'b0} >= {1'b0, den_s[NW]};
    q_rnd = QW'(quo_s[NW]) + QW'(rnd);
    lim   = (QW'(1) << (OUT_WIDTH - 1)) - QW'(!ctrl_s[NW].neg);
    q_sat = (q_rnd > lim) ? lim : q_rnd;
    q_sgn = ctrl_s[NW].neg ? -q_sat : q_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_o <= ctrl_s[NW].zero ? '0 : q_sgn[OUT_WIDTH-1:0];
    end
  end

endmodule

### design/small_matrix_inverse_top.sv
// Top level: small matrix inverse by adjugate and nine divider lanes
//
//   channel  dir  payload
//   in_i     in   order, a_00 .. a_22
//   out_o    out  inv_00 .. inv_22, status
//
// One item per cycle while the result is not stalled. Most of the pipeline is
// the one-bit-per-stage divider pipeline in each lane.
// Reset clears the valid line only. A stalled result freezes the whole
// pipeline; bubbles ahead of it are not squeezed out.
`timescale 1ns / 1ps
module small_matrix_inverse_top #(
  parameter int ENTRY_WIDTH = 12,
  parameter int FRAC_BITS = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  sminv_in_if.sink   in_i,
  sminv_out_if.source out_o
);
  import sminv_pkg::*;

  localparam int NW  = 2 * ENTRY_WIDTH + FRAC_BITS;
  localparam int DW  = 3 * ENTRY_WIDTH + 3;
  localparam int LAT = 6 + NW;

  logic                            en;
  logic [LAT-1:0]                  vld_q;
  logic signed [ENTRY_WIDTH-1:0]   a [9];
  logic [NW-1:0]                   num [9];
  logic [DW-1:0]                   den;
  lane_ctrl_t                      ctrl [9];
  status_e                         status_f;
  status_e                         st_q [NW+1];
  logic signed [OUT_WIDTH-1:0]     inv [9];

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  assign a[0] = in_i.a_00;
  assign a[1] = in_i.a_01;
  assign a[2] = in_i.a_02;
  assign a[3] = in_i.a_10;
  assign a[4] = in_i.a_11;
  assign a[5] = in_i.a_12;
  assign a[6] = in_i.a_20;
  assign a[7] = in_i.a_21;
  assign a[8] = in_i.a_22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  sminv_front #(.EW(ENTRY_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .order_i  (in_i.order),
    .a_i      (a),
    .num_o    (num),
    .den_o    (den),
    .ctrl_o   (ctrl),
    .status_o (status_f)
  );

  for (genvar m = 0; m < 9; m++) begin : g_lane
    sminv_lane #(.NW(NW), .DW(DW)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num[m]),
      .den_i  (den),
      .ctrl_i (ctrl[m]),
      .inv_o  (inv[m])
    );
  end

  // status travels beside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= status_f;
      for (int k = 1; k <= NW; k++) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  assign out_o.valid  = vld_q[LAT-1];
  assign out_o.inv_00 = inv[0];
  assign out_o.inv_01 = inv[1];
  assign out_o.inv_02 = inv[2];
  assign out_o.inv_10 = inv[3];
  assign out_o.inv_11 = inv[4];
  assign out_o.inv_12 = inv[5];
  assign out_o.inv_20 = inv[6];
  assign out_o.inv_21 = inv[7];
  assign out_o.inv_22 = inv[8];
  assign out_o.status = st_q[NW];

endmodule

### design/sminv_checker.sv
// Checker: port-level properties of the small matrix inverse, bound to the top
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sminv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic       inv_any_i
);
  import sminv_pkg::*;

  `SMINV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SMINV_ASSERT(a_status_code, clk_i, rst_ni, out_valid_i |-> (status_i <= STATUS_BAD_ORDER), "bad status code")
  `SMINV_ASSERT(a_err_zero, clk_i, rst_ni, (out_valid_i && status_i != STATUS_OK) |-> !inv_any_i, "nonzero inverse on error")
  `SMINV_ASSERT(a_in_ready, clk_i, rst_ni, !(out_valid_i && !out_ready_i) |-> in_ready_i, "input blocked without stall")

endmodule

bind small_matrix_inverse_top sminv_checker u_sminv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .inv_any_i   (|{out_o.inv_00, out_o.inv_01, out_o.inv_02, out_o.inv_10, out_o.inv_11,
                  out_o.inv_12, out_o.inv_20, out_o.inv_21, out_o.inv_22})
);
